FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on aclk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/fmbs_pkg.sv
// ----------------------------------------------------------------------------
// fmbs_pkg
// Shared constants, codes and control structures for the binary search unit.
// ----------------------------------------------------------------------------
package fmbs_pkg;

    localparam int DEPTH_DEF      = 1024;
    localparam int VALUE_BITS_DEF = 32;

    localparam int KIND_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int POS_W      = 10;
    localparam int M_TDATA_W  = ((POS_W + 7) / 8) * 8;

    localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_FOUND     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

    typedef struct packed {
        logic wr_entry;
        logic clr_count;
        logic start_search;
        logic issue_read;
        logic step;
        logic load_out;
        logic out_full;
    } fmbs_cmd_t;

    typedef struct packed {
        logic count_full;
        logic range_open;
    } fmbs_stat_t;

endpackage

FILE: src/first_match_binary_search_unit.sv
// ----------------------------------------------------------------------------
// first_match_binary_search_unit
// Sorted table of signed values with a first-occurrence binary search.
//
//   Channel   Ports       tuser (low bit up)   tdata (low bit up)
//   input     s_axis_*    kind                 value, zero padded
//   result    m_axis_*    status               position, zero padded
//
// Load, clear and unused kinds take one cycle and the next beat is taken
// straight after. A query makes at most floor(log2(entry count)) + 1 probes,
// each one read of the entry memory and one compare. A query or a dropped
// load holds off the next beat until its result is registered.
// The entry memory is not cleared at reset; only the entry count is.
// A result waiting on m_axis_tready holds the unit only when the next
// result is ready to be registered.
// ----------------------------------------------------------------------------
module first_match_binary_search_unit #(
    parameter int DEPTH      = fmbs_pkg::DEPTH_DEF,
    parameter int VALUE_BITS = fmbs_pkg::VALUE_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [((VALUE_BITS+7)/8)*8-1:0]     s_axis_tdata,  // value
    input  logic [fmbs_pkg::KIND_W-1:0]         s_axis_tuser,  // kind
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [fmbs_pkg::M_TDATA_W-1:0]      m_axis_tdata,  // position
    output logic [fmbs_pkg::STATUS_W-1:0]       m_axis_tuser   // status
);
    import fmbs_pkg::*;

    fmbs_cmd_t          cmd;
    fmbs_stat_t         stat;
    logic [POS_W-1:0]   position;

    fmbs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .kind    (s_axis_tuser),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    fmbs_datapath #(
        .DEPTH      (DEPTH),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .value    (s_axis_tdata[VALUE_BITS-1:0]),
        .status   (m_axis_tuser),
        .position (position)
    );

    assign m_axis_tdata = M_TDATA_W'(position);

`include "assert_macros.svh"

    `ASSERT_NEXT(a_query_busy,
        s_axis_tvalid && s_axis_tready && s_axis_tuser == KIND_QUERY,
        !s_axis_tready, "Unit took a beat while a query was under way.")

    `ASSERT_SAME(a_miss_zero_pos,
        m_axis_tvalid && m_axis_tuser != STATUS_FOUND,
        m_axis_tdata == '0, "Position is not zero on a miss or dropped load.")

    `ASSERT_SAME(a_result_after_busy,
        $rose(m_axis_tvalid), $past(!s_axis_tready),
        "Result appeared without the unit having been busy.")

endmodule

FILE: src/fmbs_datapath.sv
// ----------------------------------------------------------------------------
// fmbs_datapath
// Entry memory, entry count, search bounds, comparator and result register.
// ----------------------------------------------------------------------------
module fmbs_datapath #(
    parameter int DEPTH      = fmbs_pkg::DEPTH_DEF,
    parameter int VALUE_BITS = fmbs_pkg::VALUE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  fmbs_pkg::fmbs_cmd_t           cmd,
    output fmbs_pkg::fmbs_stat_t          stat,
    input  logic [VALUE_BITS-1:0]         value,
    output logic [fmbs_pkg::STATUS_W-1:0] status,
    output logic [fmbs_pkg::POS_W-1:0]    position
);
    import fmbs_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);

    logic [VALUE_BITS-1:0] mem [DEPTH];
    logic [VALUE_BITS-1:0] rd_data_reg;

    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      lo_reg, lo_next;
    logic [CNT_W-1:0]      hi_reg, hi_next;
    logic [IDX_W-1:0]      mid_reg;
    logic [IDX_W-1:0]      pos_reg, pos_next;
    logic                  found_reg, found_next;
    logic [VALUE_BITS-1:0] key_reg;
    logic [STATUS_W-1:0]   status_reg;
    logic [POS_W-1:0]      position_reg;

    logic [CNT_W-1:0]      span;
    logic [CNT_W-1:0]      mid_calc;

    assign span     = hi_reg - lo_reg - CNT_W'(1);
    assign mid_calc = lo_reg + (span >> 1);

    assign stat.count_full = (count_reg == CNT_W'(DEPTH));
    assign stat.range_open = (lo_reg < hi_reg);

    always_ff @(posedge aclk) begin
        if (cmd.wr_entry) begin
            mem[count_reg[IDX_W-1:0]] <= value;
        end
        if (cmd.issue_read) begin
            rd_data_reg <= mem[mid_calc[IDX_W-1:0]];
        end
    end

    always_comb begin
        count_next = count_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        pos_next   = pos_reg;
        found_next = found_reg;
        if (cmd.wr_entry) begin
            count_next = count_reg + CNT_W'(1);
        end else if (cmd.clr_count) begin
            count_next = '0;
        end
        if (cmd.start_search) begin
            lo_next    = '0;
            hi_next    = count_reg;
            found_next = 1'b0;
            pos_next   = '0;
        end else if (cmd.step) begin
            if ($signed(rd_data_reg) == $signed(key_reg)) begin
                found_next = 1'b1;
                pos_next   = mid_reg;
                hi_next    = CNT_W'(mid_reg);
            end else if ($signed(rd_data_reg) > $signed(key_reg)) begin
                hi_next = CNT_W'(mid_reg);
            end else begin
                lo_next = CNT_W'(mid_reg) + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        pos_reg   <= pos_next;
        found_reg <= found_next;
        if (cmd.start_search) begin
            key_reg <= value;
        end
        if (cmd.issue_read) begin
            mid_reg <= mid_calc[IDX_W-1:0];
        end
        if (cmd.load_out) begin
            if (cmd.out_full) begin
                status_reg   <= STATUS_FULL;
                position_reg <= '0;
            end else if (found_reg) begin
                status_reg   <= STATUS_FOUND;
                position_reg <= POS_W'(pos_reg);
            end else begin
                status_reg   <= STATUS_NOT_FOUND;
                position_reg <= '0;
            end
        end
    end

    assign status   = status_reg;
    assign position = position_reg;

endmodule

FILE: src/fmbs_ctrl.sv
// ----------------------------------------------------------------------------
// fmbs_ctrl
// Controller that sequences loads, clears and probe steps and owns the
// handshakes of both channels.
// ----------------------------------------------------------------------------
module fmbs_ctrl (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [fmbs_pkg::KIND_W-1:0] kind,
    output logic                        m_valid,
    input  logic                        m_ready,
    input  fmbs_pkg::fmbs_stat_t        stat,
    output fmbs_pkg::fmbs_cmd_t         cmd
);
    import fmbs_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROBE,
        S_COMPARE,
        S_DONE,
        S_DROP
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   accept;
    logic   out_free;

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    unique case (kind)
                        KIND_LOAD: begin
                            if (stat.count_full) begin
                                state_next = S_DROP;
                            end else begin
                                cmd.wr_entry = 1'b1;
                            end
                        end
                        KIND_QUERY: begin
                            cmd.start_search = 1'b1;
                            state_next       = S_PROBE;
                        end
                        KIND_CLEAR: begin
                            cmd.clr_count = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_PROBE: begin
                if (stat.range_open) begin
                    cmd.issue_read = 1'b1;
                    state_next     = S_COMPARE;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_COMPARE: begin
                cmd.step   = 1'b1;
                state_next = S_PROBE;
            end
            S_DONE: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_DROP: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    cmd.out_full = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

FILE: sim/tb_first_match_binary_search_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_first_match_binary_search_unit
// Self-checking bench for the first-occurrence binary search unit. Tables are
// loaded mostly in ascending order with repeated values, then queried for hits,
// near misses and extremes. One run fills the table and pushes loads past
// capacity. An internal table model predicts every result beat, and both
// stream sides stall at random.
// ----------------------------------------------------------------------------
module tb_first_match_binary_search_unit;

    import fmbs_pkg::*;

    localparam int TABLE_DEPTH   = DEPTH_DEF;
    localparam int TARGET_OPS    = 1300;
    localparam int STALL_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 40;

    typedef struct {
        logic [KIND_W-1:0] kind;
        int                value;
    } table_op_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    position;
    } search_result_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [31:0]            s_axis_tdata = '0;   // value
    logic [KIND_W-1:0]      s_axis_tuser = '0;   // kind
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_axis_tdata;        // position
    logic [STATUS_W-1:0]    m_axis_tuser;        // status

    table_op_t       pending_ops[$];
    search_result_t  expected_results[$];
    table_op_t       driven_op;
    search_result_t  oldest_result;
    int              entry_mem [0:TABLE_DEPTH-1];
    int              entry_count = 0;
    int              accepted_count = 0;
    int              total_ops = 1;
    int              planned_ops = 0;
    int              error_count = 0;
    int              quiet_cycles = 0;

    first_match_binary_search_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #1 aclk = ~aclk;

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic add_op(input logic [KIND_W-1:0] kind, input int value);
        table_op_t op;
        op.kind  = kind;
        op.value = value;
        pending_ops.push_back(op);
        if (kind != KIND_UNUSED) begin
            planned_ops++;
        end
    endtask

    function automatic int pick_value();
        case ($urandom_range(0, 5))
            0: return int'($urandom_range(0, 20)) - 10;
            1: return int'(32'h8000_0000 + $urandom_range(0, 3));
            2: return int'(32'h7fff_ffff - $urandom_range(0, 3));
            default: return int'($urandom);
        endcase
    endfunction

    function automatic int idle_phase();
        return (accepted_count * 3) / total_ops;
    endfunction

    // Table model: load, clear and first-occurrence search on signed values.
    task automatic apply_table_op(input table_op_t op);
        search_result_t res;
        int lo;
        int hi;
        int mid;
        res = '0;
        case (op.kind)
            KIND_LOAD: begin
                if (entry_count >= TABLE_DEPTH) begin
                    res.status = STATUS_FULL;
                    expected_results.push_back(res);
                end else begin
                    entry_mem[entry_count] = op.value;
                    entry_count++;
                end
            end
            KIND_CLEAR: begin
                entry_count = 0;
            end
            KIND_QUERY: begin
                lo = 0;
                hi = entry_count - 1;
                res.status = STATUS_NOT_FOUND;
                while (lo <= hi) begin
                    mid = lo + (hi - lo) / 2;
                    if (entry_mem[mid] == op.value) begin
                        res.status   = STATUS_FOUND;
                        res.position = mid[POS_W-1:0];
                        hi = mid - 1;
                    end else if (entry_mem[mid] > op.value) begin
                        hi = mid - 1;
                    end else begin
                        lo = mid + 1;
                    end
                end
                expected_results.push_back(res);
            end
            default: ;
        endcase
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                apply_table_op(driven_op);
                accepted_count++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_ops.size() != 0 &&
                    !(idle_phase() == 0 && $urandom_range(0, 99) < 8) &&
                    !(idle_phase() == 1 && $urandom_range(0, 99) < 71)) begin
                    driven_op = pending_ops.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= driven_op.value;
                    s_axis_tuser  <= driven_op.kind;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result beat status %0d position %0d not expected",
                                              m_axis_tuser, m_axis_tdata));
                end else begin
                    oldest_result = expected_results.pop_front();
                    if (m_axis_tuser !== oldest_result.status) begin
                        report_mismatch($sformatf("status got %0d expected %0d",
                                                  m_axis_tuser, oldest_result.status));
                    end
                    if (m_axis_tdata !== {{(M_TDATA_W-POS_W){1'b0}}, oldest_result.position}) begin
                        report_mismatch($sformatf("position got %0d expected %0d",
                                                  m_axis_tdata, oldest_result.position));
                    end
                end
            end
            case (idle_phase())
                0: m_axis_tready <= ($urandom_range(0, 99) >= 71);
                1: m_axis_tready <= ($urandom_range(0, 99) >= 8);
                default: m_axis_tready <= 1'b1;
            endcase
        end
    end

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        int  loaded[$];
        int  pool[$];
        int  n_loads;
        int  n_queries;
        int  k;
        bit  filled;
        longint run_val;

        // Directed part: empty table, extremes, repeats, unused kind, clear.
        add_op(KIND_QUERY, 5);
        add_op(KIND_UNUSED, 7);
        add_op(KIND_LOAD, int'(32'h8000_0000));
        add_op(KIND_LOAD, -5);
        add_op(KIND_LOAD, -5);
        add_op(KIND_LOAD, 0);
        add_op(KIND_LOAD, 7);
        add_op(KIND_LOAD, 7);
        add_op(KIND_LOAD, 7);
        add_op(KIND_LOAD, int'(32'h7fff_ffff));
        add_op(KIND_QUERY, int'(32'h8000_0000));
        add_op(KIND_QUERY, int'(32'h7fff_ffff));
        add_op(KIND_QUERY, -5);
        add_op(KIND_QUERY, 7);
        add_op(KIND_QUERY, 0);
        add_op(KIND_QUERY, 6);
        add_op(KIND_QUERY, -6);
        add_op(KIND_UNUSED, -1);
        add_op(KIND_QUERY, 7);
        add_op(KIND_CLEAR, int'($urandom));
        add_op(KIND_QUERY, 7);
        add_op(KIND_LOAD, 42);
        add_op(KIND_QUERY, 42);

        filled = 1'b0;
        while (planned_ops < TARGET_OPS) begin
            if (!filled && planned_ops >= 200) begin
                // Fill to capacity with ascending values, then overflow.
                filled = 1'b1;
                loaded.delete();
                add_op(KIND_CLEAR, 0);
                run_val = -64'sd2147483648 + $urandom_range(0, 1000);
                for (int i = 0; i < TABLE_DEPTH; i++) begin
                    add_op(KIND_LOAD, int'(run_val));
                    loaded.push_back(int'(run_val));
                    if ($urandom_range(0, 3) != 0) begin
                        run_val += $urandom_range(1, 4000000);
                    end
                end
                for (int i = 0; i < 3; i++) begin
                    add_op(KIND_LOAD, int'($urandom));
                end
                add_op(KIND_QUERY, loaded[0]);
                add_op(KIND_QUERY, loaded[TABLE_DEPTH-1]);
                add_op(KIND_QUERY, int'(32'h8000_0000));
                add_op(KIND_QUERY, int'(32'h7fff_ffff));
                for (int i = 0; i < 10; i++) begin
                    k = $urandom_range(0, TABLE_DEPTH - 1);
                    add_op(KIND_QUERY, loaded[k] + ($urandom_range(0, 2) == 0 ? 1 : 0));
                end
                add_op(KIND_UNUSED, int'($urandom));
            end else begin
                if ($urandom_range(0, 99) < 85) begin
                    add_op(KIND_CLEAR, int'($urandom));
                end
                n_loads = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 100)
                                                      : $urandom_range(0, 20);
                pool.delete();
                k = $urandom_range(1, (n_loads > 0) ? n_loads : 1);
                for (int i = 0; i < k; i++) begin
                    pool.push_back(pick_value());
                end
                loaded.delete();
                for (int i = 0; i < n_loads; i++) begin
                    loaded.push_back(pool[$urandom_range(0, pool.size() - 1)]);
                end
                if ($urandom_range(0, 9) != 0) begin
                    loaded.sort();
                end
                foreach (loaded[i]) begin
                    add_op(KIND_LOAD, loaded[i]);
                    if ($urandom_range(0, 49) == 0) begin
                        add_op(KIND_UNUSED, int'($urandom));
                    end
                end
                n_queries = $urandom_range(1, 8);
                for (int i = 0; i < n_queries; i++) begin
                    if (loaded.size() == 0 || $urandom_range(0, 3) == 0) begin
                        add_op(KIND_QUERY, pick_value());
                    end else begin
                        k = loaded[$urandom_range(0, loaded.size() - 1)];
                        case ($urandom_range(0, 3))
                            0: add_op(KIND_QUERY, k + 1);
                            1: add_op(KIND_QUERY, k - 1);
                            default: add_op(KIND_QUERY, k);
                        endcase
                    end
                end
            end
        end
        total_ops = pending_ops.size();

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_ops.size() != 0 || s_axis_tvalid) begin
            @(posedge aclk);
        end
        while (expected_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (expected_results.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
        end
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+src
src/fmbs_pkg.sv
src/fmbs_datapath.sv
src/fmbs_ctrl.sv
src/first_match_binary_search_unit.sv
sim/tb_first_match_binary_search_unit.sv
